// ===== rtl/cfph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_pkg
// types and constants shared by the cluster formation packet handler
// ----------------------------------------------------------------------------
package cfph_pkg;

    localparam int ADDR_W        = 16;
    localparam int KIND_W        = 2;
    localparam int MEMBER_DEPTH  = 16;
    localparam int CLUSTER_SLOTS = 4;
    localparam int SLOT_FIELDS   = 4;
    localparam int QUEUE_DEPTH   = 2;

    localparam int MEMBER_CNT_W = $clog2(MEMBER_DEPTH + 1);
    localparam int MEMBER_IDX_W = (MEMBER_DEPTH > 1) ? $clog2(MEMBER_DEPTH) : 1;
    localparam int EXTRA_W      = $clog2(CLUSTER_SLOTS + 2);
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [KIND_W-1:0] {
        KIND_BCAST   = 2'd0,
        KIND_RECRUIT = 2'd1,
        KIND_JOIN    = 2'd2
    } t_kind;

    // one packet leaving the block
    typedef struct packed {
        t_kind                   kind;
        t_addr                   msg_id;
        t_addr                   origin;
        t_addr                   net_dst;
        t_addr                   link_dst;
        logic                    is_bcast;
        t_addr [SLOT_FIELDS-1:0] slots;
        logic                    last;
    } t_pkt;

    // work handed from front to back: a lead packet and a run of recruits
    typedef struct packed {
        t_pkt                    lead;
        logic [EXTRA_W-1:0]      extra_cnt;
        t_addr                   extra_origin;
    } t_job;

endpackage

// ===== rtl/cfph_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_in_if
// received packet channel
// ----------------------------------------------------------------------------
interface cfph_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           packet_kind;
    cfph_pkg::t_addr      message_id;
    cfph_pkg::t_addr      origin_address;
    cfph_pkg::t_addr      sender_address;
    cfph_pkg::t_addr      cluster_slot0;
    cfph_pkg::t_addr      cluster_slot1;
    cfph_pkg::t_addr      cluster_slot2;
    cfph_pkg::t_addr      cluster_slot3;

    modport source (
        output valid, packet_kind, message_id, origin_address, sender_address,
               cluster_slot0, cluster_slot1, cluster_slot2, cluster_slot3,
        input  ready
    );
    modport sink (
        input  valid, packet_kind, message_id, origin_address, sender_address,
               cluster_slot0, cluster_slot1, cluster_slot2, cluster_slot3,
        output ready
    );
endinterface

// ===== rtl/cfph_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_out_if
// sent packet channel
// ----------------------------------------------------------------------------
interface cfph_out_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           out_kind;
    cfph_pkg::t_addr      out_message_id;
    cfph_pkg::t_addr      out_origin;
    cfph_pkg::t_addr      out_net_destination;
    cfph_pkg::t_addr      out_link_destination;
    logic                 out_is_broadcast;
    cfph_pkg::t_addr      out_slot0;
    cfph_pkg::t_addr      out_slot1;
    cfph_pkg::t_addr      out_slot2;
    cfph_pkg::t_addr      out_slot3;
    logic                 out_last;

    modport source (
        output valid, out_kind, out_message_id, out_origin, out_net_destination,
               out_link_destination, out_is_broadcast, out_slot0, out_slot1,
               out_slot2, out_slot3, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_kind, out_message_id, out_origin, out_net_destination,
               out_link_destination, out_is_broadcast, out_slot0, out_slot1,
               out_slot2, out_slot3, out_last,
        output ready
    );
endinterface

// ===== rtl/cfph_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_cfg_if
// own address write channel
// ----------------------------------------------------------------------------
interface cfph_cfg_if;
    logic                 valid;
    logic                 ready;
    cfph_pkg::t_addr      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/cfph_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_front
// accepts received packets, updates node state and queues the send work
// ----------------------------------------------------------------------------
module cfph_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfph_in_if.sink           i_pkt,
    cfph_cfg_if.sink          i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output cfph_pkg::t_job    o_job
);
    import cfph_pkg::*;

    logic                    r_seen_valid, n_seen_valid;
    t_addr                   r_seen_id, n_seen_id;
    t_addr                   r_sink_addr, n_sink_addr;
    t_addr                   r_head_addr, n_head_addr;
    logic                    r_head_known, n_head_known;
    t_addr                   r_back_hop, n_back_hop;
    t_addr                   r_own_addr;
    logic [MEMBER_CNT_W-1:0] r_member_cnt, n_member_cnt;
    t_addr                   r_member_table [MEMBER_DEPTH];

    logic                    accept;
    logic                    member_we;
    logic [EXTRA_W-1:0]      match_cnt;
    t_addr [SLOT_FIELDS-1:0] slot_in;
    t_job                    job;
    logic                    push;

    assign i_pkt.ready = !i_full;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_pkt.valid && i_pkt.ready;

    assign slot_in[0] = i_pkt.cluster_slot0;
    assign slot_in[1] = i_pkt.cluster_slot1;
    assign slot_in[2] = i_pkt.cluster_slot2;
    assign slot_in[3] = i_pkt.cluster_slot3;

    // slots naming this node
    always_comb begin
        match_cnt = '0;
        for (int i = 0; i < SLOT_FIELDS; i++) begin
            if (i < CLUSTER_SLOTS && slot_in[i] == r_own_addr) begin
                match_cnt = match_cnt + EXTRA_W'(1);
            end
        end
    end

    always_comb begin
        n_seen_valid = r_seen_valid;
        n_seen_id    = r_seen_id;
        n_sink_addr  = r_sink_addr;
        n_head_addr  = r_head_addr;
        n_head_known = r_head_known;
        n_back_hop   = r_back_hop;
        n_member_cnt = r_member_cnt;
        member_we    = 1'b0;
        push         = 1'b0;
        job          = '0;
        job.lead.kind = KIND_JOIN;
        if (accept) begin
            case (i_pkt.packet_kind)
                KIND_BCAST: begin
                    if (!(r_seen_valid && r_seen_id == i_pkt.message_id)) begin
                        n_seen_valid          = 1'b1;
                        n_seen_id             = i_pkt.message_id;
                        n_sink_addr           = i_pkt.origin_address;
                        push                  = 1'b1;
                        job.lead.kind         = KIND_BCAST;
                        job.lead.msg_id       = i_pkt.message_id;
                        job.lead.origin       = i_pkt.origin_address;
                        job.lead.is_bcast     = 1'b1;
                        job.lead.slots        = slot_in;
                        job.extra_cnt         = match_cnt;
                        job.extra_origin      = r_own_addr;
                        if (match_cnt != '0) begin
                            n_head_addr  = r_own_addr;
                            n_head_known = 1'b1;
                        end
                    end
                end
                KIND_RECRUIT: begin
                    if (!r_head_known) begin
                        n_head_addr       = i_pkt.origin_address;
                        n_head_known      = 1'b1;
                        n_back_hop        = i_pkt.sender_address;
                        push              = 1'b1;
                        job.lead.kind     = KIND_JOIN;
                        job.lead.origin   = r_own_addr;
                        job.lead.net_dst  = i_pkt.origin_address;
                        job.lead.link_dst = i_pkt.sender_address;
                        job.extra_cnt     = EXTRA_W'(1);
                        job.extra_origin  = i_pkt.origin_address;
                    end
                end
                KIND_JOIN: begin
                    if (r_head_known && r_head_addr == r_own_addr) begin
                        if (r_member_cnt < MEMBER_CNT_W'(MEMBER_DEPTH)) begin
                            member_we    = 1'b1;
                            n_member_cnt = r_member_cnt + MEMBER_CNT_W'(1);
                        end
                    end else begin
                        push              = 1'b1;
                        job.lead.kind     = KIND_JOIN;
                        job.lead.origin   = i_pkt.origin_address;
                        job.lead.net_dst  = r_back_hop;
                        job.lead.link_dst = r_back_hop;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_valid <= 1'b0;
            r_seen_id    <= '0;
            r_sink_addr  <= '0;
            r_head_addr  <= '0;
            r_head_known <= 1'b0;
            r_back_hop   <= '0;
            r_member_cnt <= '0;
            r_own_addr   <= '0;
        end else begin
            r_seen_valid <= n_seen_valid;
            r_seen_id    <= n_seen_id;
            r_sink_addr  <= n_sink_addr;
            r_head_addr  <= n_head_addr;
            r_head_known <= n_head_known;
            r_back_hop   <= n_back_hop;
            r_member_cnt <= n_member_cnt;
            if (i_cfg.valid && i_cfg.ready) begin
                r_own_addr <= i_cfg.data;
            end
        end
    end

    // member table
    always_ff @(posedge i_clk) begin
        if (member_we) begin
            r_member_table[r_member_cnt[MEMBER_IDX_W-1:0]] <= i_pkt.origin_address;
        end
    end

    assign o_push = push;
    assign o_job  = job;

endmodule

// ===== rtl/cfph_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_queue
// short work queue between front and back
// ----------------------------------------------------------------------------
module cfph_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfph_pkg::t_job    i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output cfph_pkg::t_job    o_data
);
    import cfph_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/cfph_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfph_back
// expands queued work into sent packets, one per cycle unless the output stalls, into an output register
// ----------------------------------------------------------------------------
module cfph_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cfph_pkg::t_job    i_job,
    output logic              o_pop,
    cfph_out_if.source        o_pkt
);
    import cfph_pkg::*;

    t_job               r_job;
    logic               r_busy;
    logic               r_first;
    logic [EXTRA_W-1:0] r_rem;
    t_pkt               r_out;
    logic               r_out_valid;

    logic               adv;
    logic               emit;
    logic               emit_last;
    logic               pop;
    t_pkt               pkt;

    assign adv  = !r_out_valid || o_pkt.ready;
    assign emit = r_busy && adv;

    always_comb begin
        if (r_first) begin
            pkt      = r_job.lead;
            pkt.last = (r_job.extra_cnt == '0);
        end else begin
            pkt          = '0;
            pkt.kind     = KIND_RECRUIT;
            pkt.origin   = r_job.extra_origin;
            pkt.is_bcast = 1'b1;
            pkt.last     = (r_rem == EXTRA_W'(1));
        end
    end

    assign emit_last = emit && pkt.last;
    assign pop       = i_valid && (!r_busy || emit_last);
    assign o_pop     = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_first     <= 1'b0;
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_busy  <= 1'b1;
                r_first <= 1'b1;
            end else begin
                if (emit_last) begin
                    r_busy <= 1'b0;
                end
                if (emit) begin
                    r_first <= 1'b0;
                end
            end
            if (emit) begin
                r_rem <= r_first ? r_job.extra_cnt : r_rem - EXTRA_W'(1);
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (adv) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out <= pkt;
        end
    end

    assign o_pkt.valid                = r_out_valid;
    assign o_pkt.out_kind             = r_out.kind;
    assign o_pkt.out_message_id       = r_out.msg_id;
    assign o_pkt.out_origin           = r_out.origin;
    assign o_pkt.out_net_destination  = r_out.net_dst;
    assign o_pkt.out_link_destination = r_out.link_dst;
    assign o_pkt.out_is_broadcast     = r_out.is_bcast;
    assign o_pkt.out_slot0            = r_out.slots[0];
    assign o_pkt.out_slot1            = r_out.slots[1];
    assign o_pkt.out_slot2            = r_out.slots[2];
    assign o_pkt.out_slot3            = r_out.slots[3];
    assign o_pkt.out_last             = r_out.last;

endmodule

// ===== rtl/cluster_formation_packet_handler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cluster_formation_packet_handler
// cluster formation routing: handles received broadcast, recruit and join
// packets and sends the packets this node answers with
// ----------------------------------------------------------------------------
// A received packet is taken while the two-entry work queue has room; node
// state (last broadcast id, head, back hop, member table) is updated at that
// transfer. The back end sends one packet per cycle while the output is not
// stalled; an input causes one to five sent packets, or none. The first sent
// packet passes the queue entry, the back end job register and the output
// register. The own address register is written through the configuration
// channel, which is always ready.
module cluster_formation_packet_handler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfph_in_if.sink    i_pkt,
    cfph_cfg_if.sink   i_cfg,
    cfph_out_if.source o_pkt
);
    import cfph_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_job push_job;
    t_job q_job;

    cfph_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    cfph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_job)
    );

    cfph_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_pkt   (o_pkt)
    );

endmodule
